[rtl/query_frame_builder_crc16_assert.svh]
// assertion macros shared by the query frame builder
`ifndef QUERY_FRAME_BUILDER_CRC16_ASSERT_SVH
`define QUERY_FRAME_BUILDER_CRC16_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every rising clock edge outside reset
`define QFB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("qfb assertion failed");
// condition that must never be true outside reset
`define QFB_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("qfb forbidden condition seen");
`else
`define QFB_ASSERT(lbl, clk, rst_n, prop)
`define QFB_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/qfb_pkg.sv]
`default_nettype none

package qfb_pkg;

    // frame layout
    localparam int unsigned FrameLen  = 10;
    localparam int unsigned BodyLen   = 8;
    localparam int unsigned NumDigits = 6;
    localparam int unsigned IdxW      = 4;

    localparam logic [IdxW-1:0] IdxStx   = IdxW'(0);
    localparam logic [IdxW-1:0] IdxEnq   = IdxW'(BodyLen - 1);
    localparam logic [IdxW-1:0] IdxCrcLo = IdxW'(BodyLen);
    localparam logic [IdxW-1:0] IdxCrcHi = IdxW'(FrameLen - 1);

    localparam logic [7:0]  CodeStx = 8'h02;
    localparam logic [7:0]  CodeEnq = 8'h05;
    localparam logic [15:0] CrcPoly = 16'hA001;
    localparam logic [15:0] CrcInit = 16'hFFFF;

    // request queue geometry
    localparam int unsigned QDepth = 2;
    localparam int unsigned QAw    = 1;
    localparam int unsigned QCntW  = 2;

    // six ascii hex digits of the frame body, node digit at index 0
    typedef logic [NumDigits-1:0][7:0] t_body;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // lower-case ascii hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] v;
        v = {4'b0000, n};
        if (n < 4'd10) begin
            hex_digit = 8'h30 + v;
        end else begin
            hex_digit = 8'h57 + v;
        end
    endfunction

    // reflected crc-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        crc_byte = c;
    endfunction

endpackage

`default_nettype wire

[rtl/qfb_front.sv]
`default_nettype none

module qfb_front
    import qfb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // node_id[3:0], function_code[11:4], tag_value[15:12], first_axis[19:16],
    // axis_count[23:20]
    input  wire logic [23:0] i_s_tdata,
    input  wire t_q_stat     i_q_stat,
    output logic             o_push,
    output t_body            o_body
);

    logic  r_valid;
    t_body r_body;
    t_body n_body;
    logic  w_accept;

    // hand the encoded item to the queue whenever there is room
    assign o_push     = r_valid && !i_q_stat.full;
    assign o_s_tready = !r_valid || !i_q_stat.full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_body     = r_body;

    // encode fields into ascii hex digits
    always_comb begin
        n_body[0] = hex_digit(i_s_tdata[3:0]);
        n_body[1] = hex_digit(i_s_tdata[11:8]);
        n_body[2] = hex_digit(i_s_tdata[7:4]);
        n_body[3] = hex_digit(i_s_tdata[15:12]);
        n_body[4] = hex_digit(i_s_tdata[19:16]);
        n_body[5] = hex_digit(i_s_tdata[23:20]);
    end

    // holding slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // holding slot payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_body <= n_body;
        end
    end

endmodule

`default_nettype wire

[rtl/qfb_queue.sv]
`default_nettype none

module qfb_queue
    import qfb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_body i_body,
    input  wire logic  i_pop,
    output t_body      o_body,
    output t_q_stat    o_stat
);

    t_body            r_mem [QDepth];
    logic [QAw-1:0]   r_wp;
    logic [QAw-1:0]   r_rp;
    logic [QCntW-1:0] r_cnt;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCntW'(QDepth));
    assign o_body       = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAw'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAw'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCntW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCntW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_body;
        end
    end

endmodule

`default_nettype wire

[rtl/qfb_back.sv]
`default_nettype none

module qfb_back
    import qfb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_crc_start,
    input  wire t_q_stat     i_q_stat,
    input  wire t_body       i_body,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // frame_byte[7:0]
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast
);

    logic            r_busy;
    logic [IdxW-1:0] r_idx;
    logic [15:0]     r_crc;
    t_body           r_body;
    logic            r_tvalid;
    logic [7:0]      r_tdata;
    logic            r_tlast;

    logic            n_busy;
    logic [IdxW-1:0] n_idx;
    logic [15:0]     n_crc;

    logic            w_adv;
    logic            w_emit;
    logic            w_last;
    logic [7:0]      w_byte;

    // output register moves when empty or taken
    assign w_adv  = !r_tvalid || i_m_tready;
    assign w_emit = r_busy && w_adv;
    assign w_last = (r_idx == IdxCrcHi);
    assign o_pop  = !i_q_stat.empty && (!r_busy || (w_emit && w_last));

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;

    // byte at the current frame position
    always_comb begin
        case (r_idx)
            IdxStx:   w_byte = CodeStx;
            4'd1:     w_byte = r_body[0];
            4'd2:     w_byte = r_body[1];
            4'd3:     w_byte = r_body[2];
            4'd4:     w_byte = r_body[3];
            4'd5:     w_byte = r_body[4];
            4'd6:     w_byte = r_body[5];
            IdxEnq:   w_byte = CodeEnq;
            IdxCrcLo: w_byte = r_crc[7:0];
            IdxCrcHi: w_byte = r_crc[15:8];
            default:  w_byte = 8'h00;
        endcase
    end

    // sequencer next values
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_crc  = r_crc;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = IdxStx;
            n_crc  = i_crc_start;
        end else if (w_emit) begin
            n_idx = r_idx + IdxW'(1);
            if (w_last) begin
                n_busy = 1'b0;
            end
            if (r_idx < IdxCrcLo) begin
                n_crc = crc_byte(r_crc, w_byte);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= IdxStx;
            r_tvalid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (w_adv) begin
                r_tvalid <= w_emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (o_pop) begin
            r_body <= i_body;
        end
        if (w_adv) begin
            r_tdata <= w_byte;
            r_tlast <= w_last;
        end
    end

endmodule

`default_nettype wire

[rtl/query_frame_builder_crc16.sv]
`default_nettype none

// Query frame builder: each request item on the slave stream becomes a ten-byte
// frame on the master stream: STX, node digit, two function-code digits, tag,
// first-axis and axis-count digits (lower-case ascii hex), ENQ, then the
// reflected CRC-16 (poly 0xA001) over those eight bytes, low byte first; tlast
// marks the CRC high byte. The CRC start value comes from the config channel
// (reset 0xFFFF) and should only change while no frame is in flight. Frames
// stream at one byte per cycle while the receiver is ready, paced by the
// byte-wide serializer; the CRC folds in one byte per cycle as it goes out.
// A two-deep request queue plus an input holding slot let up to three
// requests wait while a frame is being sent; an accepted request passes the
// holding slot, a queue entry and the serializer's registers on its way out.
module query_frame_builder_crc16
    import qfb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // node_id[3:0], function_code[11:4], tag_value[15:12], first_axis[19:16],
    // axis_count[23:20]
    input  wire logic [23:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // frame_byte[7:0]
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    // crc_start[15:0]
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_crc_start;
    logic        w_push;
    logic        w_pop;
    t_body       w_front_body;
    t_body       w_q_body;
    t_q_stat     w_q_stat;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_start <= CrcInit;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_crc_start <= i_cfg_data;
        end
    end

    // request encoder
    qfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_body     (w_front_body)
    );

    // request queue
    qfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_body  (w_front_body),
        .i_pop   (w_pop),
        .o_body  (w_q_body),
        .o_stat  (w_q_stat)
    );

    // frame serializer with crc
    qfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_crc_start (r_crc_start),
        .i_q_stat    (w_q_stat),
        .i_body      (w_q_body),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // queue never overflows or underflows
`include "query_frame_builder_crc16_assert.svh"
    `QFB_NEVER(a_no_push_full, i_clk, i_rst_n, w_push && w_q_stat.full)
    `QFB_NEVER(a_no_pop_empty, i_clk, i_rst_n, w_pop && w_q_stat.empty)
    // input side stalls only when the holding slot is stuck behind a full queue
    `QFB_ASSERT(a_ready_when_room, i_clk, i_rst_n, !w_q_stat.full |-> o_s_tready)

endmodule

`default_nettype wire

[verif/query_frame_builder_crc16_checker.sv]
`timescale 1ns / 1ps

// watches the request, frame and config channels, predicts each query frame
// and compares the frame bytes in order
module query_frame_builder_crc16_checker
    import qfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_bytes_due
);

    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_last;
    } t_frame_byte;

    t_frame_byte frame_bytes_due[$];
    logic [15:0] crc_seed;

    // lower-case ascii digit for one nibble
    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        if (nib <= 4'd9) begin
            return 8'h30 + {4'h0, nib};
        end else begin
            return 8'h61 + {4'h0, nib - 4'd10};
        end
    endfunction

    // reflected crc, one input bit at a time, lsb first
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ CrcPoly;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // build the ten expected bytes for one request
    function automatic void predict_frame(input logic [23:0] req);
        logic [7:0]  body [8];
        logic [15:0] crc;
        body[0] = CodeStx;
        body[1] = ascii_hex(req[3:0]);
        body[2] = ascii_hex(req[11:8]);
        body[3] = ascii_hex(req[7:4]);
        body[4] = ascii_hex(req[15:12]);
        body[5] = ascii_hex(req[19:16]);
        body[6] = ascii_hex(req[23:20]);
        body[7] = CodeEnq;
        crc = crc_seed;
        for (int i = 0; i < 8; i++) begin
            crc = crc16_fold(crc, body[i]);
            frame_bytes_due.push_back('{byte_val: body[i], is_last: 1'b0});
        end
        frame_bytes_due.push_back('{byte_val: crc[7:0], is_last: 1'b0});
        frame_bytes_due.push_back('{byte_val: crc[15:8], is_last: 1'b1});
    endfunction

    initial begin
        o_fail_count = 0;
        o_bytes_due  = 0;
        crc_seed     = 16'hFFFF;
    end

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_frame_byte exp_item;
        if (!i_rst_n) begin
            frame_bytes_due.delete();
            crc_seed = 16'hFFFF;
        end else begin
            // frame byte out
            if (i_m_tvalid && i_m_tready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("frame byte 8'h%02h (frame_end %b) with none expected",
                           i_m_tdata, i_m_tlast);
                    o_fail_count++;
                end else begin
                    exp_item = frame_bytes_due.pop_front();
                    if (i_m_tdata !== exp_item.byte_val) begin
                        $error("frame_byte: expected 8'h%02h, got 8'h%02h",
                               exp_item.byte_val, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== exp_item.is_last) begin
                        $error("frame_end: expected %b, got %b",
                               exp_item.is_last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            // crc start write
            if (i_cfg_valid && i_cfg_ready) begin
                crc_seed = i_cfg_data;
            end
            // request in
            if (i_s_tvalid && i_s_tready) begin
                predict_frame(i_s_tdata);
            end
        end
        o_bytes_due = frame_bytes_due.size();
    end

endmodule

[verif/query_frame_builder_crc16_tb.sv]
`timescale 1ns / 1ps

module query_frame_builder_crc16_tb;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned ItemsPerPhase = 40;

    typedef enum int {RxFree, RxRandom, RxPattern} t_rx_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_ready;

    int          fail_count;
    int          bytes_due;

    t_rx_mode    rx_mode = RxFree;
    int          hold_cycles_left = 0;
    int          rx_tick = 0;
    logic        tx_gaps_on = 1'b0;
    int          tx_burst_left = 0;
    int          n_requests = 0;
    int          n_crc_loads = 0;
    int unsigned cycle_count = 0;

    query_frame_builder_crc16 dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    query_frame_builder_crc16_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_bytes_due  (bytes_due)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk) begin
        cycle_count++;
    end

    initial begin
        wait (cycle_count == CycleLimit);
        $display("watchdog expired after %0d cycles, %0d bytes still due",
                 cycle_count, bytes_due);
        $display("*** FAILED ***");
        $finish;
    end

    // frame receiver: long hold-off first, otherwise the current stall mode
    always @(negedge clk) begin
        rx_tick++;
        if (hold_cycles_left > 0) begin
            m_tready = 1'b0;
            hold_cycles_left--;
        end else begin
            case (rx_mode)
                RxFree: begin
                    m_tready = 1'b1;
                end
                RxRandom: begin
                    m_tready = ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_tready = ((rx_tick % 7) != 3) && ((rx_tick % 23) > 4);
                end
            endcase
        end
    end

    function automatic logic [23:0] pack_request(input logic [3:0] node, input logic [7:0] fcode,
                                                 input logic [3:0] tag, input logic [3:0] axis,
                                                 input logic [3:0] count);
        return {count, axis, tag, fcode, node};
    endfunction

    // offer one request, in bursts with random gaps between them when gaps are on
    task automatic offer_request(input logic [23:0] req);
        int   gap;
        logic ready_seen;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 12);
            if (tx_gaps_on) begin
                gap = $urandom_range(1, 14);
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        tx_burst_left--;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = req;
        // ready is stable between the falling and the next rising edge
        do begin
            ready_seen = s_tready;
            @(posedge clk);
            if (!ready_seen) @(negedge clk);
        end while (!ready_seen);
        n_requests++;
    endtask

    // sender idles until every expected byte is out
    task automatic wait_frames_out();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (bytes_due != 0) @(negedge clk);
    endtask

    task automatic load_crc_start(input logic [15:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        n_crc_loads++;
    endtask

    task automatic offer_random_requests(input int n);
        for (int i = 0; i < n; i++) begin
            offer_request(24'($urandom()));
        end
    endtask

    // stimulus
    initial begin
        logic [23:0] corner_reqs [10];
        logic [15:0] phase_seed [5];

        corner_reqs[0] = pack_request(4'h0, 8'h00, 4'h0, 4'h0, 4'h0);
        corner_reqs[1] = pack_request(4'hF, 8'hFF, 4'hF, 4'hF, 4'hF);
        corner_reqs[2] = pack_request(4'h9, 8'h9A, 4'hA, 4'h9, 4'hA);
        corner_reqs[3] = pack_request(4'hA, 8'hA9, 4'h9, 4'hA, 4'h9);
        corner_reqs[4] = pack_request(4'h1, 8'h03, 4'h2, 4'h0, 4'h4);
        corner_reqs[5] = pack_request(4'h5, 8'h5A, 4'hA, 4'h5, 4'hA);
        corner_reqs[6] = pack_request(4'hA, 8'hA5, 4'h5, 4'hA, 4'h5);
        corner_reqs[7] = pack_request(4'hF, 8'h0F, 4'h0, 4'hF, 4'h0);
        corner_reqs[8] = pack_request(4'h0, 8'hF0, 4'hF, 4'h0, 4'hF);
        corner_reqs[9] = pack_request(4'h3, 8'h10, 4'h7, 4'h1, 4'h2);

        phase_seed[0] = 16'($urandom());
        phase_seed[1] = 16'hA001;
        phase_seed[2] = 16'h8000;
        phase_seed[3] = 16'h0001;
        phase_seed[4] = 16'($urandom());

        // reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner requests with the crc start left at its reset value
        rx_mode = RxFree;
        foreach (corner_reqs[i]) offer_request(corner_reqs[i]);
        wait_frames_out();

        // crc start extremes
        rx_mode = RxRandom;
        load_crc_start(16'h0000);
        for (int i = 0; i < 4; i++) offer_request(corner_reqs[i]);
        wait_frames_out();
        load_crc_start(16'hFFFF);
        for (int i = 4; i < 8; i++) offer_request(corner_reqs[i]);
        wait_frames_out();

        // receiver holds off while the sender keeps pushing
        @(posedge clk);
        hold_cycles_left = 250;
        tx_gaps_on = 1'b0;
        offer_random_requests(8);
        wait_frames_out();

        // random phases, each with its own crc start and idling mix
        for (int p = 0; p < 5; p++) begin
            load_crc_start(phase_seed[p]);
            case (p % 3)
                0: rx_mode = RxRandom;
                1: rx_mode = RxPattern;
                default: rx_mode = RxFree;
            endcase
            tx_gaps_on = (p != 2);
            tx_burst_left = 0;
            offer_random_requests(ItemsPerPhase);
            wait_frames_out();
        end

        repeat (30) @(negedge clk);

        $display("%0d query requests checked across %0d crc start loads", n_requests,
                 n_crc_loads);
        $display("covered corner digits, crc start extremes, long output hold-off, drains");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/qfb_pkg.sv
rtl/qfb_front.sv
rtl/qfb_queue.sv
rtl/qfb_back.sv
rtl/query_frame_builder_crc16.sv
verif/query_frame_builder_crc16_checker.sv
verif/query_frame_builder_crc16_tb.sv
